### hdl/dfuh_pkg.sv
// ----------------------------------------------------------------------------
// dfuh_pkg: shared types and constants of the object transfer host
// Protocol opcodes, state and result codes, queue entry type and CRC step.
// ----------------------------------------------------------------------------
package dfuh_pkg;

  localparam int unsigned OBJECT_MAX   = 4096;
  localparam int unsigned PRN_INTERVAL = 32;
  localparam int unsigned OBJ_W        = $clog2(OBJECT_MAX + 1);
  localparam int unsigned PRN_W        = 6;

  localparam logic [7:0] OP_CREATE    = 8'h01;
  localparam logic [7:0] OP_CRC       = 8'h03;
  localparam logic [7:0] OP_EXEC      = 8'h04;
  localparam logic [7:0] OP_WRITE     = 8'h08;
  localparam logic [7:0] OP_PING      = 8'h09;
  localparam logic [7:0] OP_RESP      = 8'h60;
  localparam logic [7:0] PING_TAG     = 8'h01;
  localparam logic [7:0] OBJ_INIT     = 8'h01;
  localparam logic [7:0] OBJ_APP      = 8'h02;
  localparam logic [7:0] RES_OK       = 8'h01;
  localparam logic [7:0] RES_NOT_SUPP = 8'h02;
  localparam logic [7:0] RES_EXT      = 8'h0B;

  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_POLL  = 3'd2;
  localparam logic [2:0] CMD_TICK  = 3'd3;
  localparam logic [2:0] CMD_RSP   = 3'd4;
  localparam logic [2:0] CMD_BYTE  = 3'd5;

  localparam logic [2:0] REG_INIT_SIZE = 3'd0;
  localparam logic [2:0] REG_APP_SIZE  = 3'd1;
  localparam logic [2:0] REG_CHUNK_LEN = 3'd2;
  localparam logic [2:0] REG_IS_BLE    = 3'd3;
  localparam logic [2:0] REG_TIMEOUT   = 3'd4;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_STARTED  = 3'd2;
  localparam logic [2:0] PH_PROGRESS = 3'd3;
  localparam logic [2:0] PH_DONE     = 3'd4;
  localparam logic [2:0] PH_ERROR    = 3'd5;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_CRC    = 3'd1;
  localparam logic [2:0] ERR_REMOTE = 3'd2;
  localparam logic [2:0] ERR_TIME   = 3'd3;
  localparam logic [2:0] ERR_FRAME  = 3'd4;
  localparam logic [2:0] ERR_BUSY   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEND_PING, ST_WAIT_PING, ST_CREATE, ST_WAIT_CREATE, ST_WRITE,
    ST_STREAM, ST_REQ_CRC, ST_WAIT_CRC, ST_REQ_EXEC, ST_WAIT_EXEC, ST_DONE, ST_ERROR
  } proto_state_t;

  typedef enum logic [2:0] {
    RK_NONE, RK_PING, RK_CREATE, RK_WRITE, RK_CRC, RK_EXEC, RK_BYTE
  } res_kind_t;

  // One queue entry: everything the back end needs to emit a step's results
  typedef struct packed {
    res_kind_t    kind;
    logic [7:0]   data;
    logic         last;
    logic         no_opcode;
    logic         image;
    logic [23:0]  offset;
    logic [12:0]  length;
    logic [OBJ_W-1:0] obj_size;
    logic [2:0]   phase;
    logic [2:0]   error_code;
    logic [7:0]   ext_error;
  } res_desc_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
    end
    return ~c;
  endfunction

endpackage

### hdl/dfuh_if.sv
// ----------------------------------------------------------------------------
// dfuh_if: channel interfaces of the object transfer host
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface dfuh_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  payload_byte;
  logic [7:0]  rsp_lead;
  logic [7:0]  rsp_op;
  logic [7:0]  rsp_result;
  logic [7:0]  rsp_ext;
  logic [31:0] rsp_crc;
  modport source (output valid, cmd, payload_byte, rsp_lead, rsp_op, rsp_result,
                  rsp_ext, rsp_crc, input ready);
  modport sink (input valid, cmd, payload_byte, rsp_lead, rsp_op, rsp_result,
                rsp_ext, rsp_crc, output ready);
endinterface

interface dfuh_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic        fetch_valid;
  logic        fetch_image;
  logic [23:0] fetch_offset;
  logic [12:0] fetch_length;
  logic [2:0]  phase;
  logic [2:0]  error_code;
  logic [7:0]  ext_error;
  modport source (output valid, tx_valid, tx_byte, tx_last, fetch_valid, fetch_image,
                  fetch_offset, fetch_length, phase, error_code, ext_error, input ready);
  modport sink (input valid, tx_valid, tx_byte, tx_last, fetch_valid, fetch_image,
                fetch_offset, fetch_length, phase, error_code, ext_error, output ready);
endinterface

interface dfuh_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/dfuh_front.sv
// ----------------------------------------------------------------------------
// dfuh_front: command decoder and protocol state
// Takes one input transaction a cycle while the queue has room, updates the
// exchange state and queues a descriptor of the results it causes.
// ----------------------------------------------------------------------------
module dfuh_front import dfuh_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  dfuh_in_if.sink       in_ch,
  dfuh_cfg_if.sink      cfg,
  output logic          push_valid,
  output res_desc_t     push_desc,
  input  logic          push_ready
);

  logic [23:0] init_size, app_size;
  logic [12:0] chunk_len;
  logic        is_ble;
  logic [15:0] timeout_ticks;

  proto_state_t st, st_next, prev_st, prev_st_next;
  logic             retry, retry_next, img, img_next;
  logic [23:0]      ofs, ofs_next;
  logic [OBJ_W-1:0] oleft, oleft_next;
  logic [12:0]      cleft, cleft_next, csize, csize_next;
  logic [PRN_W-1:0] prn, prn_next;
  logic [31:0]      crc, crc_next;
  logic [15:0]      tick, tick_next;
  logic [2:0]       phase, phase_next, lerr, lerr_next;
  logic [7:0]       ext, ext_next;

  logic        accept, busy, fin, err_set, clr;
  logic [2:0]  err_code;
  logic [7:0]  err_ext;
  logic [23:0] sz, rem;
  logic [12:0] cl, n;
  logic        act;
  res_desc_t   d;

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign push_valid  = in_ch.valid;
  assign push_desc   = d;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_size <= '0; app_size <= '0; chunk_len <= 13'd64; is_ble <= 1'b0;
      timeout_ticks <= 16'd5;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_INIT_SIZE: init_size <= cfg.data;
        REG_APP_SIZE:  app_size <= cfg.data;
        REG_CHUNK_LEN: chunk_len <= cfg.data[12:0];
        REG_IS_BLE:    is_ble <= cfg.data[0];
        REG_TIMEOUT:   timeout_ticks <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE; prev_st <= ST_IDLE; retry <= 1'b0; img <= 1'b0; ofs <= '0;
      oleft <= '0; cleft <= '0; csize <= '0; prn <= '0; crc <= '0; tick <= '0;
      phase <= PH_IDLE; lerr <= ERR_NONE; ext <= '0;
    end else if (accept) begin
      st <= st_next; prev_st <= prev_st_next; retry <= retry_next; img <= img_next;
      ofs <= ofs_next; oleft <= oleft_next; cleft <= cleft_next; csize <= csize_next;
      prn <= prn_next; crc <= crc_next; tick <= tick_next; phase <= phase_next;
      lerr <= lerr_next; ext <= ext_next;
    end
  end

  always_comb begin
    st_next = st; prev_st_next = prev_st; retry_next = retry; img_next = img;
    ofs_next = ofs; oleft_next = oleft; cleft_next = cleft; csize_next = csize;
    prn_next = prn; crc_next = crc; tick_next = tick; phase_next = phase;
    lerr_next = lerr; ext_next = ext;
    busy = 1'b0; fin = 1'b0; err_set = 1'b0; clr = 1'b0;
    err_code = ERR_NONE; err_ext = '0;
    d = '0;
    d.kind = RK_NONE;
    sz  = img ? app_size : init_size;
    rem = (ofs < sz) ? sz - ofs : 24'd0;
    if (rem > 24'(OBJECT_MAX)) rem = 24'(OBJECT_MAX);
    cl  = (chunk_len == 13'd0) ? 13'd1 : chunk_len;
    n   = (24'(oleft) < 24'(cl)) ? 13'(oleft) : cl;
    act = (st >= ST_SEND_PING) && (st <= ST_WAIT_EXEC);

    case (in_ch.cmd)
      CMD_START: begin
        if (phase != PH_IDLE) begin
          busy = 1'b1;
        end else begin
          clr = 1'b1; retry_next = 1'b0; lerr_next = ERR_NONE; ext_next = '0;
          tick_next = '0; phase_next = PH_STARTED; st_next = ST_SEND_PING;
        end
      end
      CMD_STOP: begin
        clr = 1'b1; st_next = ST_IDLE; phase_next = PH_IDLE; lerr_next = ERR_NONE;
        ext_next = '0; retry_next = 1'b0; tick_next = '0;
      end
      CMD_POLL: begin
        case (st)
          ST_SEND_PING: begin
            d.kind = RK_PING; st_next = ST_WAIT_PING;
          end
          ST_CREATE: begin
            d.kind = RK_CREATE; d.image = img; d.obj_size = OBJ_W'(rem);
            oleft_next = OBJ_W'(rem); st_next = ST_WAIT_CREATE;
          end
          ST_WRITE: begin
            d.kind = RK_WRITE; d.no_opcode = is_ble; d.image = img;
            d.offset = ofs; d.length = n;
            csize_next = n; cleft_next = n;
            if (n == 13'd0) fin = 1'b1;
            else st_next = ST_STREAM;
          end
          ST_REQ_CRC: begin
            d.kind = RK_CRC; st_next = ST_WAIT_CRC;
          end
          ST_REQ_EXEC: begin
            d.kind = RK_EXEC; st_next = ST_WAIT_EXEC;
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (act && st == prev_st) begin
          if (tick != 16'hFFFF) tick_next = tick + 16'd1;
          if (tick_next >= timeout_ticks) begin
            err_set = 1'b1; err_code = ERR_TIME;
          end
        end
      end
      CMD_RSP: begin
        if (act) begin
          if (in_ch.rsp_lead != OP_RESP) begin
            err_set = 1'b1; err_code = ERR_FRAME;
          end else if (st == ST_WAIT_PING && in_ch.rsp_op == OP_PING
                       && in_ch.rsp_result == RES_OK) begin
            st_next = ST_CREATE; phase_next = PH_PROGRESS;
          end else if (st == ST_WAIT_PING && in_ch.rsp_result == RES_NOT_SUPP && !retry) begin
            st_next = ST_SEND_PING; retry_next = 1'b1;
          end else if (st == ST_WAIT_CREATE && in_ch.rsp_op == OP_CREATE
                       && in_ch.rsp_result == RES_OK) begin
            st_next = ST_WRITE;
          end else if (st == ST_WAIT_CRC && in_ch.rsp_op == OP_CRC
                       && in_ch.rsp_result == RES_OK) begin
            if (in_ch.rsp_crc != crc) begin
              err_set = 1'b1; err_code = ERR_CRC;
            end else begin
              st_next = (oleft == '0) ? ST_REQ_EXEC : ST_WRITE;
            end
          end else if (st == ST_WAIT_EXEC && in_ch.rsp_op == OP_EXEC
                       && in_ch.rsp_result == RES_OK) begin
            if (ofs >= sz) begin
              if (!img) begin
                img_next = 1'b1; ofs_next = '0; crc_next = '0; prn_next = '0;
                st_next = ST_CREATE;
              end else begin
                clr = 1'b1; st_next = ST_DONE; phase_next = PH_DONE;
              end
            end else begin
              st_next = ST_CREATE;
            end
          end else if (in_ch.rsp_result != RES_OK) begin
            err_set = 1'b1; err_code = ERR_REMOTE;
            err_ext = (in_ch.rsp_result == RES_EXT) ? in_ch.rsp_ext : 8'd0;
          end
        end
      end
      CMD_BYTE: begin
        if (st == ST_STREAM) begin
          crc_next = crc_byte(crc, in_ch.payload_byte);
          if (cleft != 13'd0) cleft_next = cleft - 13'd1;
          d.kind = RK_BYTE; d.data = in_ch.payload_byte;
          d.last = (cleft_next == 13'd0);
          if (cleft_next == 13'd0) fin = 1'b1;
        end
      end
      default: ;
    endcase

    // Chunk has passed: advance offset and object counters, then request a CRC check or the next write
    if (fin) begin
      ofs_next   = ofs + 24'(csize_next);
      oleft_next = (24'(csize_next) <= 24'(oleft)) ? oleft - OBJ_W'(csize_next) : '0;
      csize_next = '0;
      cleft_next = '0;
      if (prn + PRN_W'(1) >= PRN_W'(PRN_INTERVAL) || oleft_next == '0) begin
        prn_next = '0; st_next = ST_REQ_CRC;
      end else begin
        prn_next = prn + PRN_W'(1); st_next = ST_WRITE;
      end
    end
    if (err_set) begin
      clr = 1'b1; st_next = ST_ERROR; phase_next = PH_ERROR;
      lerr_next = err_code; ext_next = err_ext;
    end
    if (clr) begin
      img_next = 1'b0; ofs_next = '0; oleft_next = '0; cleft_next = '0;
      csize_next = '0; prn_next = '0; crc_next = '0;
    end
    if (st_next != prev_st) begin
      prev_st_next = st_next; tick_next = '0;
    end
    d.phase      = phase_next;
    d.error_code = busy ? ERR_BUSY : lerr_next;
    d.ext_error  = ext_next;
  end

  a_idle_state: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (st == ST_IDLE)) else $error("idle phase outside idle state");
  a_stream_left: assert property (@(posedge clk) disable iff (rst)
    (st == ST_STREAM) |-> (cleft != 13'd0)) else $error("streaming with empty chunk");
  a_prn_range: assert property (@(posedge clk) disable iff (rst)
    prn < PRN_W'(PRN_INTERVAL)) else $error("chunk count beyond interval");

endmodule

### hdl/dfuh_queue.sv
// ----------------------------------------------------------------------------
// dfuh_queue: two-entry descriptor queue
// Decouples the decoder from the result emitter.
// ----------------------------------------------------------------------------
module dfuh_queue import dfuh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  input  res_desc_t push_desc,
  output logic      push_ready,
  output logic      pop_valid,
  output res_desc_t pop_desc,
  input  logic      pop
);

  res_desc_t  mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_desc   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0; rd_ptr <= 1'b0; count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue overfilled");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |=> (count <= 2'd1)) else $error("queue count jumped");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr)) else $error("pointer slip");

endmodule

### hdl/dfuh_back.sv
// ----------------------------------------------------------------------------
// dfuh_back: result emitter
// Expands the queue head into its bytes and fetch request, one a cycle while out_ch is ready.
// ----------------------------------------------------------------------------
module dfuh_back import dfuh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  res_desc_t head,
  output logic      pop,
  dfuh_out_if.source out_ch
);

  logic [2:0]  idx;
  logic [2:0]  total;
  logic [31:0] size32;
  logic        fire;

  assign size32 = 32'(head.obj_size);
  assign fire   = head_valid && out_ch.ready;
  assign pop    = fire && (idx == total - 3'd1);
  assign out_ch.valid      = head_valid;
  assign out_ch.phase      = head.phase;
  assign out_ch.error_code = head.error_code;
  assign out_ch.ext_error  = head.ext_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= pop ? 3'd0 : idx + 3'd1;
    end
  end

  always_comb begin
    total = 3'd1;
    out_ch.tx_valid = 1'b0; out_ch.tx_byte = '0; out_ch.tx_last = 1'b0;
    out_ch.fetch_valid = 1'b0; out_ch.fetch_image = 1'b0;
    out_ch.fetch_offset = '0; out_ch.fetch_length = '0;
    unique case (head.kind)
      RK_PING: begin
        total = 3'd2; out_ch.tx_valid = 1'b1;
        out_ch.tx_byte = (idx == 3'd0) ? OP_PING : PING_TAG;
        out_ch.tx_last = (idx != 3'd0);
      end
      RK_CREATE: begin
        total = 3'd6; out_ch.tx_valid = 1'b1; out_ch.tx_last = (idx == 3'd5);
        case (idx)
          3'd0: out_ch.tx_byte = OP_CREATE;
          3'd1: out_ch.tx_byte = head.image ? OBJ_APP : OBJ_INIT;
          3'd2: out_ch.tx_byte = size32[7:0];
          3'd3: out_ch.tx_byte = size32[15:8];
          3'd4: out_ch.tx_byte = size32[23:16];
          default: out_ch.tx_byte = size32[31:24];
        endcase
      end
      RK_WRITE: begin
        total = head.no_opcode ? 3'd1 : 3'd2;
        if (!head.no_opcode && idx == 3'd0) begin
          out_ch.tx_valid = 1'b1; out_ch.tx_byte = OP_WRITE; out_ch.tx_last = 1'b1;
        end else begin
          out_ch.fetch_valid = 1'b1; out_ch.fetch_image = head.image;
          out_ch.fetch_offset = head.offset; out_ch.fetch_length = head.length;
        end
      end
      RK_CRC: begin
        out_ch.tx_valid = 1'b1; out_ch.tx_byte = OP_CRC; out_ch.tx_last = 1'b1;
      end
      RK_EXEC: begin
        out_ch.tx_valid = 1'b1; out_ch.tx_byte = OP_EXEC; out_ch.tx_last = 1'b1;
      end
      RK_BYTE: begin
        out_ch.tx_valid = 1'b1; out_ch.tx_byte = head.data; out_ch.tx_last = head.last;
      end
      default: ;
    endcase
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (idx < total)) else $error("result index beyond entry");
  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !out_ch.ready) |=> $stable(idx)) else $error("index moved in stall");
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> !(out_ch.tx_valid && out_ch.fetch_valid)) else $error("byte and fetch");

endmodule

### hdl/dfu_object_transfer_host_unit.sv
// ----------------------------------------------------------------------------
// dfu_object_transfer_host_unit: host side of an object firmware-update link
// Runs ping, create, chunked write, CRC check and execute for both images.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries commands (start, stop, poll, tick, response, payload
//          byte); one transaction is accepted per cycle while the queue has
//          room.
//   out_ch carries results: link bytes, fetch requests for the next chunk
//          and a status word (phase, error code, extended error) on each.
//   cfg    writes the size, chunk length, link-type and timeout registers;
//          always ready, write only while the unit is idle.
// Each input transaction yields one to six result transactions. The decoder
// updates protocol state in the cycle of acceptance and queues a descriptor;
// the emitter hands out one result a cycle while the receiver is ready, so
// the first result of an item follows its descriptor through the queue and a
// stream of payload bytes runs at one byte per cycle. Commands causing several
// results (create: six) occupy the emitter until all are handed out; the
// two-entry queue sets how far the decoder may run ahead.
// Reset clears protocol state, the queue and the registers to their defaults.
// When the receiver stalls, hold the current result; the queue fills and the
// input channel drops ready until room is free.
// ----------------------------------------------------------------------------
module dfu_object_transfer_host_unit import dfuh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dfuh_in_if.sink    in_ch,
  dfuh_cfg_if.sink   cfg,
  dfuh_out_if.source out_ch
);

  // Decoder to queue
  logic      push_valid, push_ready;
  res_desc_t push_desc;
  // Queue to emitter
  logic      head_valid, pop;
  res_desc_t head;

  dfuh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .push_ready (push_ready)
  );

  dfuh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_desc  (push_desc),
    .push_ready (push_ready),
    .pop_valid  (head_valid),
    .pop_desc   (head),
    .pop        (pop)
  );

  dfuh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
